// ----- hw/rtl/rut_pkg.sv -----
// Package for the RUT check-digit validator: beat types, codes and constants.
package rut_pkg;

	localparam int unsigned NUM_W          = 27;
	localparam int unsigned CH_W           = 8;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned DIGIT_WINDOW_D = 8;

	localparam logic [NUM_W-1:0] NUM_MAX          = {NUM_W{1'b1}};
	localparam logic [NUM_W-1:0] PERSON_LOW_RST   = NUM_W'(1000000);
	localparam logic [NUM_W-1:0] PERSON_HIGH_RST  = NUM_W'(30000000);
	localparam logic [NUM_W-1:0] COMPANY_LOW_RST  = NUM_W'(50000000);
	localparam logic [NUM_W-1:0] COMPANY_HIGH_RST = NUM_W'(99999999);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERSON_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERSON_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMPANY_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMPANY_HIGH = 2'd3;

	// Characters the parser cares about
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_UP_K  = 8'h4B;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CH_W-1:0] CASE_GAP = 8'h20;

	localparam logic [3:0] CHECK_K = 4'd10;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_SIGN   = 3'd1,
		PH_DIGITS = 3'd2,
		PH_DASH   = 3'd3,
		PH_DONE   = 3'd4,
		PH_FAIL   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_RANGE     = 2'd2,
		ST_WRONG     = 2'd3
	} status_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
	} char_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] check_value;
		logic       valid_res;
	} res_beat_t;

endpackage

// ----- hw/rtl/rut_check_digit_validator_top.sv -----
// RUT check-digit validator: character parser, range check and mod-11 check.
// Latency: the result beat is registered in the cycle after the character beat marked last is accepted.
// Throughput: one character per cycle while char_stall is low; the parse step and the fixed-weight
// digit sum with its reciprocal mod-11 are combinational ahead of the result register.
// Reset: arst_n clears the parser state and the result valid at once and loads the
// range registers with their default limits; no clearing pass is needed.
module rut_check_digit_validator_top
	import rut_pkg::*;
#(
	parameter int unsigned DIGIT_WINDOW = DIGIT_WINDOW_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  char_beat_t           char_beat,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_beat_t            res_beat,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]     cfg_data
);

	localparam int unsigned WIN_W  = 4 * DIGIT_WINDOW;
	localparam int unsigned SUM_W  = $clog2(9 * 7 * DIGIT_WINDOW + 1);
	// floor(x * 373 / 4096) equals x / 11 for every sum this window can reach
	localparam int unsigned RECIP   = 373;
	localparam int unsigned RECIP_W = 9;
	localparam int unsigned SHIFT   = 12;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;

	// Range registers
	logic [NUM_W-1:0] person_low_q, person_high_q, company_low_q, company_high_q;

	// Parser state
	phase_t           phase_q, phase_n;
	logic [NUM_W-1:0] number_q, number_n;
	logic             ovf_q, ovf_n;
	logic             neg_q, neg_n;
	logic [WIN_W-1:0] window_q, window_n;
	logic [CH_W-1:0]  entered_q, entered_n;

	// Result register
	logic      res_valid_q;
	res_beat_t res_beat_q, res_beat_n;

	logic            accept;
	logic [CH_W-1:0] c;
	logic            is_digit;
	logic [3:0]      dig;
	logic [NUM_W+3:0] num_times10;

	logic [SUM_W-1:0]  wsum;
	logic [PROD_W-1:0] qprod;
	logic [SUM_W-1:0]  quot;
	logic [SUM_W-1:0]  rem;
	logic [3:0]        check;
	logic [CH_W-1:0]   e_up;
	logic [CH_W-1:0]   want;
	logic              in_range;

	assign cfg_ready  = 1'b1;
	assign char_stall = res_valid_q & res_stall;
	assign accept     = char_valid & ~char_stall;
	assign res_valid  = res_valid_q;
	assign res_beat   = res_beat_q;

	assign c           = char_beat.ch;
	assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
	assign dig         = 4'(c - CH_ZERO);
	assign num_times10 = {1'b0, number_q, 3'b000} + {3'b000, number_q, 1'b0}
	                     + {(NUM_W)'(0), dig};

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			person_low_q   <= PERSON_LOW_RST;
			person_high_q  <= PERSON_HIGH_RST;
			company_low_q  <= COMPANY_LOW_RST;
			company_high_q <= COMPANY_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PERSON_LOW:   person_low_q   <= cfg_data;
				REG_PERSON_HIGH:  person_high_q  <= cfg_data;
				REG_COMPANY_LOW:  company_low_q  <= cfg_data;
				REG_COMPANY_HIGH: company_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parser next state for one character
	always_comb begin
		phase_n   = phase_q;
		number_n  = number_q;
		ovf_n     = ovf_q;
		neg_n     = neg_q;
		window_n  = window_q;
		entered_n = entered_q;
		if (c == CH_NUL && phase_q != PH_DONE && phase_q != PH_FAIL) begin
			phase_n = PH_FAIL;
		end else if (c != CH_DOT && c != CH_SPACE) begin
			case (phase_q)
				PH_LEAD: begin
					if (c >= CH_TAB && c <= CH_CR) begin
						phase_n = PH_LEAD;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						neg_n   = (c == CH_MINUS);
						phase_n = PH_SIGN;
					end else if (is_digit) begin
						phase_n = PH_DIGITS;
					end else begin
						phase_n = PH_FAIL;
					end
				end
				PH_SIGN: begin
					phase_n = is_digit ? PH_DIGITS : PH_FAIL;
				end
				PH_DIGITS: begin
					if (is_digit) begin
						phase_n = PH_DIGITS;
					end else if (c == CH_MINUS) begin
						phase_n = PH_DASH;
					end else begin
						phase_n = PH_FAIL;
					end
				end
				PH_DASH: begin
					entered_n = c;
					phase_n   = PH_DONE;
				end
				default: ;
			endcase
			// digit intake, saturating on overflow
			if (is_digit && (phase_q == PH_LEAD || phase_q == PH_SIGN
			                 || phase_q == PH_DIGITS)) begin
				if (num_times10 > {4'b0000, NUM_MAX}) begin
					ovf_n    = 1'b1;
					number_n = NUM_MAX;
				end else begin
					number_n = num_times10[NUM_W-1:0];
				end
				window_n = {window_q[WIN_W-5:0], dig};
			end
		end
	end

	// Weighted digit sum and mod 11 via reciprocal
	always_comb begin
		wsum = '0;
		for (int i = 0; i < DIGIT_WINDOW; i++) begin
			wsum = wsum + SUM_W'(window_q[4*i +: 4] * 3'(2 + (i % 6)));
		end
		qprod = PROD_W'(wsum) * PROD_W'(RECIP);
		quot  = SUM_W'(qprod >> SHIFT);
		rem   = wsum - SUM_W'(quot * SUM_W'(11));
		check = (rem == '0) ? 4'd0 : 4'(SUM_W'(11) - rem);
	end

	// Result of a beat marked last
	always_comb begin
		in_range = ((number_q >= person_low_q) && (number_q <= person_high_q)) ||
		           ((number_q >= company_low_q) && (number_q <= company_high_q));
		e_up = (entered_n >= CH_LO_A && entered_n <= CH_LO_Z) ? entered_n - CASE_GAP
		                                                      : entered_n;
		want = (check == CHECK_K) ? CH_UP_K : CH_ZERO + {4'b0000, check};
		res_beat_n.check_value = 4'd0;
		if (phase_n != PH_DONE) begin
			res_beat_n.status = ST_MALFORMED;
		end else if (ovf_q || neg_q || number_q == '0 || !in_range) begin
			res_beat_n.status = ST_RANGE;
		end else begin
			res_beat_n.check_value = check;
			res_beat_n.status      = (e_up == want) ? ST_VALID : ST_WRONG;
		end
		res_beat_n.valid_res = (res_beat_n.status == ST_VALID);
	end

	// Parser state registers; cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			number_q  <= '0;
			ovf_q     <= 1'b0;
			neg_q     <= 1'b0;
			window_q  <= '0;
			entered_q <= '0;
		end else if (accept) begin
			if (char_beat.last) begin
				phase_q   <= PH_LEAD;
				number_q  <= '0;
				ovf_q     <= 1'b0;
				neg_q     <= 1'b0;
				window_q  <= '0;
				entered_q <= '0;
			end else begin
				phase_q   <= phase_n;
				number_q  <= number_n;
				ovf_q     <= ovf_n;
				neg_q     <= neg_n;
				window_q  <= window_n;
				entered_q <= entered_n;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && char_beat.last) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept && char_beat.last) begin
			res_beat_q <= res_beat_n;
		end
	end

endmodule

// ----- tb/rut_check_digit_validator_checker.sv -----
// Checker for the RUT validator: follows register writes, predicts each status beat, compares.
module rut_check_digit_validator_checker
	import rut_pkg::*;
#(
	parameter int unsigned WINDOW = DIGIT_WINDOW_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	input  logic                 char_stall,
	input  char_beat_t           char_beat,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  res_beat_t            res_beat,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the range limits
	logic [NUM_W-1:0] lim_person_low;
	logic [NUM_W-1:0] lim_person_high;
	logic [NUM_W-1:0] lim_company_low;
	logic [NUM_W-1:0] lim_company_high;

	// Parser state as the block should hold it
	phase_t              parse_phase;
	logic [NUM_W-1:0]    acc;
	bit                  acc_sat;
	bit                  acc_neg;
	logic [4*WINDOW-1:0] recent_digits;
	logic [CH_W-1:0]     check_char;

	// Status beats still owed by the block, oldest first
	res_beat_t status_q[$];

	task automatic clear_parser();
		parse_phase   = PH_LEAD;
		acc           = '0;
		acc_sat       = 1'b0;
		acc_neg       = 1'b0;
		recent_digits = '0;
		check_char    = '0;
	endtask

	function automatic bit is_digit(logic [CH_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Accumulate one decimal digit; saturate at the top of the 27-bit range
	task automatic shift_digit(input logic [CH_W-1:0] c);
		logic [63:0] grown;
		logic [3:0]  d;
		d     = 4'(c - CH_ZERO);
		grown = 64'(acc) * 64'd10 + 64'(d);
		if (grown > 64'(NUM_MAX)) begin
			acc_sat = 1'b1;
			acc     = NUM_MAX;
		end else begin
			acc = grown[NUM_W-1:0];
		end
		recent_digits = {recent_digits[4*WINDOW-5:0], d};
	endtask

	// Weights 2..7 repeating from the least significant digit, then 11 - (sum mod 11), or 0 when that is 11
	function automatic logic [3:0] mod11_check(logic [4*WINDOW-1:0] digs);
		int unsigned sum;
		int unsigned w;
		int unsigned r;
		sum = 0;
		w   = 2;
		for (int i = 0; i < WINDOW; i++) begin
			sum += int'(digs[4*i +: 4]) * w;
			w = (w == 7) ? 2 : w + 1;
		end
		r = sum % 11;
		return (r == 0) ? 4'd0 : 4'(11 - r);
	endfunction

	// One character beat through the parser; a beat marked last yields a status
	task automatic take_char(input char_beat_t b, output bit emits, output res_beat_t r);
		logic [CH_W-1:0] c;
		logic [CH_W-1:0] e;
		logic [CH_W-1:0] want;
		logic [3:0]      chk;
		bit              in_range;
		c     = b.ch;
		emits = 1'b0;
		r     = '0;
		if (c == CH_NUL && parse_phase != PH_DONE && parse_phase != PH_FAIL) begin
			parse_phase = PH_FAIL;
		end else if (c != CH_DOT && c != CH_SPACE) begin
			case (parse_phase)
				PH_LEAD: begin
					if (is_digit(c)) begin
						shift_digit(c);
						parse_phase = PH_DIGITS;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						acc_neg     = (c == CH_MINUS);
						parse_phase = PH_SIGN;
					end else if (c < CH_TAB || c > CH_CR) begin
						parse_phase = PH_FAIL;
					end
				end
				PH_SIGN: begin
					if (is_digit(c)) begin
						shift_digit(c);
						parse_phase = PH_DIGITS;
					end else begin
						parse_phase = PH_FAIL;
					end
				end
				PH_DIGITS: begin
					if (is_digit(c))
						shift_digit(c);
					else if (c == CH_MINUS)
						parse_phase = PH_DASH;
					else
						parse_phase = PH_FAIL;
				end
				PH_DASH: begin
					check_char  = c;
					parse_phase = PH_DONE;
				end
				default: ;
			endcase
		end

		if (b.last) begin
			emits = 1'b1;
			if (parse_phase != PH_DONE) begin
				r.status = ST_MALFORMED;
			end else begin
				in_range = (acc >= lim_person_low && acc <= lim_person_high) ||
				           (acc >= lim_company_low && acc <= lim_company_high);
				if (acc_sat || acc_neg || acc == '0 || !in_range) begin
					r.status = ST_RANGE;
				end else begin
					chk  = mod11_check(recent_digits);
					e    = (check_char >= CH_LO_A && check_char <= CH_LO_Z) ?
					       check_char - CASE_GAP : check_char;
					want = (chk == CHECK_K) ? CH_UP_K : CH_ZERO + CH_W'(chk);
					r.check_value = chk;
					r.status      = (e == want) ? ST_VALID : ST_WRONG;
				end
			end
			r.valid_res = (r.status == ST_VALID);
			clear_parser();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// Watch all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		res_beat_t want;
		res_beat_t fresh;
		bit        emits;
		if (!arst_n) begin
			lim_person_low   = PERSON_LOW_RST;
			lim_person_high  = PERSON_HIGH_RST;
			lim_company_low  = COMPANY_LOW_RST;
			lim_company_high = COMPANY_HIGH_RST;
			clear_parser();
			status_q.delete();
			fail_count = 0;
			pending   <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PERSON_LOW:   lim_person_low   = cfg_data;
					REG_PERSON_HIGH:  lim_person_high  = cfg_data;
					REG_COMPANY_LOW:  lim_company_low  = cfg_data;
					REG_COMPANY_HIGH: lim_company_high = cfg_data;
					default: ;
				endcase
			end

			// A result beat always belongs to an earlier character beat
			if (res_valid && !res_stall) begin
				if (status_q.size() == 0) begin
					report_mismatch("result beat with none pending", 32'(res_beat), 32'd0);
				end else begin
					want = status_q.pop_front();
					if (res_beat.status !== want.status)
						report_mismatch("status", 32'(res_beat.status),
						                32'(want.status));
					if (res_beat.check_value !== want.check_value)
						report_mismatch("check_value", 32'(res_beat.check_value),
						                32'(want.check_value));
					if (res_beat.valid_res !== want.valid_res)
						report_mismatch("valid_res", 32'(res_beat.valid_res),
						                32'(want.valid_res));
				end
			end

			if (char_valid && !char_stall) begin
				take_char(char_beat, emits, fresh);
				if (emits)
					status_q.push_back(fresh);
			end
			pending <= status_q.size();
		end
	end

endmodule

// ----- tb/tb_rut_check_digit_validator_top.sv -----
// Testbench top for the RUT validator: clock, reset, character and register stimulus, verdict.
module tb_rut_check_digit_validator_top
	import rut_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_CHARS = 1850;
	localparam int SEGMENTS     = 8;
	localparam int DRAIN_WAIT   = 4;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 char_valid;
	logic                 char_stall;
	char_beat_t           char_beat;
	logic                 res_valid;
	logic                 res_stall;
	res_beat_t            res_beat;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NUM_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending;

	// Idle odds in percent, and the limits as last written
	int               gap_pct;
	int               stall_pct;
	int               chars_sent;
	logic [NUM_W-1:0] lims [4];

	always #CLK_HALF clk = ~clk;

	rut_check_digit_validator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_beat (char_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rut_check_digit_validator_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_beat (char_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// Send one character beat, with random idle cycles ahead of it
	task automatic send_char(input logic [CH_W-1:0] c, input logic l);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid     <= 1'b1;
		char_beat.ch   <= c;
		char_beat.last <= l;
		do @(posedge clk); while (char_stall);
		chars_sent++;
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++)
			send_char(t[i], i == t.len() - 1);
	endtask

	task automatic send_seq(input logic [CH_W-1:0] s[$]);
		foreach (s[i])
			send_char(s[i], i == s.size() - 1);
	endtask

	// Hold the sender until every owed status beat has come out
	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NUM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		lims[idx] = val;
	endtask

	task automatic write_limits(input logic [NUM_W-1:0] p_lo, input logic [NUM_W-1:0] p_hi,
	                            input logic [NUM_W-1:0] c_lo, input logic [NUM_W-1:0] c_hi);
		write_reg(REG_PERSON_LOW, p_lo);
		write_reg(REG_PERSON_HIGH, p_hi);
		write_reg(REG_COMPANY_LOW, c_lo);
		write_reg(REG_COMPANY_HIGH, c_hi);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Number biased toward the configured ranges and their borders
	function automatic longint unsigned pick_number();
		int     kind;
		longint v;
		kind = $urandom_range(99);
		if (kind < 35)
			return $urandom_range(lims[REG_PERSON_HIGH], lims[REG_PERSON_LOW]);
		if (kind < 60)
			return $urandom_range(lims[REG_COMPANY_HIGH], lims[REG_COMPANY_LOW]);
		if (kind < 75) begin
			v = longint'(lims[$urandom_range(3)]) + longint'($urandom_range(2)) - 1;
			return (v < 0) ? 0 : v;
		end
		if (kind < 85)
			return $urandom_range(99);
		return $urandom_range(99999999);
	endfunction

	// Right check character for a digit string, so most strings reach the final compare
	function automatic logic [CH_W-1:0] check_char_for(logic [3:0] ds[$]);
		int unsigned sum;
		int unsigned w;
		int unsigned r;
		int          n;
		sum = 0;
		w   = 2;
		n   = 0;
		for (int i = ds.size() - 1; i >= 0 && n < DIGIT_WINDOW_D; i--) begin
			sum += int'(ds[i]) * w;
			w = (w == 7) ? 2 : w + 1;
			n++;
		end
		r = 11 - sum % 11;
		return (r == 11) ? CH_ZERO : (r == 10) ? CH_UP_K : CH_ZERO + CH_W'(r);
	endfunction

	// Mostly well-formed identifiers with random content; some noise and broken ones
	task automatic make_string(output logic [CH_W-1:0] s[$]);
		logic [3:0]        ds[$];
		longint unsigned   v;
		int                kind;
		int                n;
		logic [CH_W-1:0]   good;
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 12)) s.push_back(CH_W'($urandom_range(255)));
			return;
		end

		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 2))
				s.push_back(($urandom_range(3) == 0) ? CH_SPACE :
				            CH_W'($urandom_range(CH_CR, CH_TAB)));
		end

		kind = $urandom_range(99);
		if (kind < 10)
			s.push_back(CH_PLUS);
		else if (kind < 16)
			s.push_back(CH_MINUS);

		// Long digit runs can overflow and exercise the digit window
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(9, 13)) ds.push_back(4'($urandom_range(9)));
		end else begin
			v = pick_number();
			do begin
				ds.push_front(4'(v % 10));
				v = v / 10;
			end while (v != 0);
			if ($urandom_range(99) < 12)
				repeat ($urandom_range(1, 3)) ds.push_front(4'd0);
		end
		foreach (ds[i]) begin
			if (i != 0 && $urandom_range(99) < 8)
				s.push_back($urandom_range(1) ? CH_DOT : CH_SPACE);
			s.push_back(CH_ZERO + CH_W'(ds[i]));
		end

		s.push_back(($urandom_range(99) < 95) ? CH_MINUS : CH_W'($urandom_range(255)));

		good = check_char_for(ds);
		kind = $urandom_range(99);
		if (kind < 65) begin
			s.push_back((good == CH_UP_K && $urandom_range(1)) ? CH_UP_K + CASE_GAP : good);
		end else if (kind < 80) begin
			n = $urandom_range(11);
			s.push_back((n == 10) ? CH_UP_K : (n == 11) ? CH_UP_K + CASE_GAP :
			            CH_ZERO + CH_W'(n));
		end else if (kind < 92) begin
			s.push_back(CH_W'($urandom_range(255)));
		end

		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 3)) s.push_back(CH_W'($urandom_range(255)));

		// Cut short, or a NUL dropped in somewhere
		kind = $urandom_range(99);
		if (kind < 5)
			s = s[0:$urandom_range(s.size() - 1)];
		else if (kind < 8)
			s.insert($urandom_range(s.size() - 1), CH_NUL);
	endtask

	// Ends the run when no beat has moved on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((char_valid && !char_stall) || (res_valid && !res_stall) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		logic [CH_W-1:0] s[$];
		int              seg_end;
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_beat  <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_PERSON_LOW;
		cfg_data   <= '0;
		gap_pct    = 0;
		stall_pct  = 0;
		chars_sent = 0;
		lims[REG_PERSON_LOW]   = PERSON_LOW_RST;
		lims[REG_PERSON_HIGH]  = PERSON_HIGH_RST;
		lims[REG_COMPANY_LOW]  = COMPANY_LOW_RST;
		lims[REG_COMPANY_HIGH] = COMPANY_HIGH_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: top code, NUL mid-string, whitespace and sign, lowercase K,
		// negative sign, digits with no dash
		send_char(8'hFF, 1'b1);
		send_char(CH_NUL, 1'b0);
		send_char(CH_ZERO + 8'd5, 1'b1);
		send_text("\t+1000005-k");
		send_text("-7-0");
		send_text("1.2 3");

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: write_limits(PERSON_LOW_RST, PERSON_HIGH_RST, COMPANY_LOW_RST,
				                COMPANY_HIGH_RST);
				1: write_limits('0, NUM_MAX, '0, NUM_MAX);
				2: write_limits(NUM_MAX, '0, NUM_MAX, '0);
				3: write_limits(NUM_W'(1), NUM_W'(1), NUM_MAX, NUM_MAX);
				default: write_limits(NUM_W'($urandom_range(99999999)),
				                      NUM_W'($urandom_range(99999999)),
				                      NUM_W'($urandom_range(99999999)),
				                      NUM_W'($urandom_range(99999999)));
			endcase
			case (seg % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 88;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 88;
				end
				default: begin
					gap_pct   = 28;
					stall_pct = 28;
				end
			endcase
			seg_end = chars_sent + RANDOM_CHARS / SEGMENTS;
			while (chars_sent < seg_end) begin
				s.delete();
				make_string(s);
				send_seq(s);
				if ($urandom_range(99) < 2)
					drain();
			end
		end

		drain();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
